// ===== design/ewmb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the world matrix builder.
package ewmb_pkg;

   localparam int SinCosWidth = 16;
   localparam int ScaleWidth = 16;
   localparam int EntryWidth = 25;
   localparam int PosWidth = 32;
   localparam int CordicWidth = 34;
   localparam int NumScales = 3;
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_X = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_Y = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_Z = 2'd2;
   localparam logic signed [ScaleWidth-1:0] SCALE_ONE = 16'sd256;
   localparam logic signed [CordicWidth-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [15:0] PI_Q13 = 16'sd25736;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [EntryWidth-1:0] ENTRY_MAX = 25'sd8388608;

   typedef logic signed [SinCosWidth-1:0] sc_type;
   typedef logic signed [PosWidth-1:0] pos_type;
   typedef logic signed [EntryWidth-1:0] entry_type;

   // Sine and cosine for the three angles plus the pass-through position.
   typedef struct packed {
      sc_type  sp;
      sc_type  cp;
      sc_type  sy;
      sc_type  cy;
      sc_type  sr;
      sc_type  cr;
      pos_type px;
      pos_type py;
      pos_type pz;
   } trig_type;

   // Arctangent table in Q0.24.
   function automatic logic [23:0] atan_q24(input int unsigned idx);
      logic [23:0] t;
      begin
         unique case (idx)
            0: t = 24'd13176795; 1: t = 24'd7778716; 2: t = 24'd4110060;
            3: t = 24'd2086331;  4: t = 24'd1047214; 5: t = 24'd524117;
            6: t = 24'd262123;   7: t = 24'd131069;
            default: t = 24'd1 << (24 - idx);
         endcase
         return t;
      end
   endfunction

   // Round Q2.30 to Q1.14 and saturate to plus or minus one.
   function automatic sc_type round_sat(input logic signed [CordicWidth-1:0] v);
      logic signed [CordicWidth:0] r;
      logic signed [CordicWidth-16:0] q;
      begin
         r = (CordicWidth+1)'(v) + (CordicWidth+1)'(34'sd32768);
         q = r[CordicWidth:16];
         if (q > 19'sd16384) return 16'sd16384;
         else if (q < -19'sd16384) return -16'sd16384;
         else return q[15:0];
      end
   endfunction

endpackage

// ===== design/ewmb_cordic_cell.sv =====
// One CORDIC micro-rotation cell: a fixed shift, add and angle update per stage.
module ewmb_cordic_cell #(
   parameter int STAGE = 0,
   parameter int ZW = 16,
   parameter int FRAC = 13
) (
   input  logic                                      clock,
   input  logic                                      adv,
   input  logic signed [ewmb_pkg::CordicWidth-1:0]   x_i,
   input  logic signed [ewmb_pkg::CordicWidth-1:0]   y_i,
   input  logic signed [ZW-1:0]                      z_i,
   input  logic                                      neg_i,
   output logic signed [ewmb_pkg::CordicWidth-1:0]   x_o,
   output logic signed [ewmb_pkg::CordicWidth-1:0]   y_o,
   output logic signed [ZW-1:0]                      z_o,
   output logic                                      neg_o
);
   localparam int Sh = 24 - FRAC;
   localparam logic [24:0] AtanRaw = 25'(ewmb_pkg::atan_q24(STAGE));
   localparam logic [24:0] AtanRnd = (AtanRaw + (25'd1 << (Sh - 1))) >> Sh;
   localparam logic signed [ZW-1:0] Atan = ZW'(AtanRnd);

   logic signed [ewmb_pkg::CordicWidth-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic neg_ff;

   always_comb begin
      if (!z_i[ZW-1]) begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         z_in = z_i - Atan;
      end else begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         z_in = z_i + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         neg_ff <= neg_i;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
   assign neg_o = neg_ff;
endmodule

// ===== design/ewmb_sincos.sv =====
// Angle reduction followed by a chain of CORDIC cells for one angle.
module ewmb_sincos #(
   parameter int TRIG_ITERATIONS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic signed [15:0]    angle,
   output ewmb_pkg::sc_type      sin_o,
   output ewmb_pkg::sc_type      cos_o
);
   localparam int Frac = ANGLE_BITS - 3;
   localparam int Zw = ANGLE_BITS + 2;
   localparam int Nc = TRIG_ITERATIONS;

   logic signed [ewmb_pkg::CordicWidth-1:0] xs [Nc+1];
   logic signed [ewmb_pkg::CordicWidth-1:0] ys [Nc+1];
   logic signed [Zw-1:0] zs [Nc+1];
   logic negs [Nc+1];
   logic signed [16:0] red;
   logic red_neg;
   logic signed [Zw+15:0] zwide;

   always_comb begin
      red = 17'(angle);
      red_neg = 1'b0;
      if (angle > ewmb_pkg::HALF_PI_Q13) begin
         red = 17'(angle) - 17'(ewmb_pkg::PI_Q13);
         red_neg = 1'b1;
      end else if (angle < -ewmb_pkg::HALF_PI_Q13) begin
         red = 17'(angle) + 17'(ewmb_pkg::PI_Q13);
         red_neg = 1'b1;
      end
      if (Frac >= 13) zwide = (Zw+16)'(red) <<< (Frac - 13);
      else zwide = (Zw+16)'(red) >>> (13 - Frac);
   end

   assign xs[0] = ewmb_pkg::CORDIC_X0;
   assign ys[0] = '0;
   assign zs[0] = zwide[Zw-1:0];
   assign negs[0] = red_neg;

   for (genvar g = 0; g < Nc; g++) begin : g_cell
      ewmb_cordic_cell #(.STAGE(g), .ZW(Zw), .FRAC(Frac)) u_cell (
         .clock(clock), .adv(adv),
         .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]), .neg_i(negs[g]),
         .x_o(xs[g+1]), .y_o(ys[g+1]), .z_o(zs[g+1]), .neg_o(negs[g+1])
      );
   end

   ewmb_pkg::sc_type s_r, c_r;
   always_comb begin
      s_r = ewmb_pkg::round_sat(ys[Nc]);
      c_r = ewmb_pkg::round_sat(xs[Nc]);
      sin_o = negs[Nc] ? -s_r : s_r;
      cos_o = negs[Nc] ? -c_r : c_r;
   end
endmodule

// ===== design/ewmb_matrix.sv =====
// Matrix product, scaling and saturation pipeline: three register stages.
module ewmb_matrix (
   input  logic                                        clock,
   input  logic                                        adv,
   input  ewmb_pkg::trig_type                          trig,
   input  logic signed [ewmb_pkg::ScaleWidth-1:0]      scale_x,
   input  logic signed [ewmb_pkg::ScaleWidth-1:0]      scale_y,
   input  logic signed [ewmb_pkg::ScaleWidth-1:0]      scale_z,
   output ewmb_pkg::entry_type                         ent [9],
   output ewmb_pkg::pos_type                           tx,
   output ewmb_pkg::pos_type                           ty,
   output ewmb_pkg::pos_type                           tz
);
   // Stage 1: pair products, Q28.
   logic signed [31:0] srsp_ff, crsp_ff, srcp_ff, crcp_ff, crcy_ff, crsy_ff;
   logic signed [31:0] srcy_ff, srsy_ff, cpsy_ff, cpcy_ff;
   ewmb_pkg::sc_type sp1_ff, sy1_ff, cy1_ff;
   // Stage 2: entries, Q28.
   logic signed [33:0] e_ff [9];
   // Stage 3: scaled, Q36.
   logic signed [50:0] p_ff [9];
   ewmb_pkg::pos_type px_ff [3], py_ff [3], pz_ff [3];

   logic signed [31:0] rsp, rcp;
   logic signed [33:0] e_in [9];
   logic signed [ewmb_pkg::ScaleWidth-1:0] scl [3];

   assign scl[0] = scale_x;
   assign scl[1] = scale_y;
   assign scl[2] = scale_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         srsp_ff <= 32'(trig.sr * trig.sp);
         crsp_ff <= 32'(trig.cr * trig.sp);
         srcp_ff <= 32'(trig.sr * trig.cp);
         crcp_ff <= 32'(trig.cr * trig.cp);
         crcy_ff <= 32'(trig.cr * trig.cy);
         crsy_ff <= 32'(trig.cr * trig.sy);
         srcy_ff <= 32'(trig.sr * trig.cy);
         srsy_ff <= 32'(trig.sr * trig.sy);
         cpsy_ff <= 32'(trig.cp * trig.sy);
         cpcy_ff <= 32'(trig.cp * trig.cy);
         sp1_ff <= trig.sp;
         sy1_ff <= trig.sy;
         cy1_ff <= trig.cy;
         px_ff[0] <= trig.px;
         py_ff[0] <= trig.py;
         pz_ff[0] <= trig.pz;
         px_ff[1] <= px_ff[0];
         py_ff[1] <= py_ff[0];
         pz_ff[1] <= pz_ff[0];
         px_ff[2] <= px_ff[1];
         py_ff[2] <= py_ff[1];
         pz_ff[2] <= pz_ff[1];
      end
   end

   always_comb begin
      rsp = (srsp_ff + 32'sd8192) >>> 14;
      rcp = (crsp_ff + 32'sd8192) >>> 14;
      e_in[0] = 34'(rsp * sy1_ff) + 34'(crcy_ff);
      e_in[1] = 34'(srcp_ff);
      e_in[2] = 34'(rsp * cy1_ff) - 34'(crsy_ff);
      e_in[3] = 34'(rcp * sy1_ff) - 34'(srcy_ff);
      e_in[4] = 34'(crcp_ff);
      e_in[5] = 34'(rcp * cy1_ff) + 34'(srsy_ff);
      e_in[6] = 34'(cpsy_ff);
      e_in[7] = -(34'(sp1_ff) <<< 14);
      e_in[8] = 34'(cpcy_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            e_ff[k] <= e_in[k];
            p_ff[k] <= 51'(e_ff[k]) * 51'(scl[k/3]);
         end
      end
   end

   logic signed [50:0] r;
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         r = (p_ff[k] + 51'sd524288) >>> 20;
         if (r > 51'(ewmb_pkg::ENTRY_MAX)) ent[k] = ewmb_pkg::ENTRY_MAX;
         else if (r < -51'(ewmb_pkg::ENTRY_MAX)) ent[k] = -ewmb_pkg::ENTRY_MAX;
         else ent[k] = r[ewmb_pkg::EntryWidth-1:0];
      end
   end

   assign tx = px_ff[2];
   assign ty = py_ff[2];
   assign tz = pz_ff[2];
endmodule

// ===== design/euler_world_matrix_builder_unit.sv =====
// Top level of the scaled yaw-pitch-roll world matrix builder.
// Usage: a transfer on the req_ channel carries three angles (Q2.13 radians)
// and a position (Q16.16). Each accepted item yields exactly one transfer on
// the rsp_ channel with nine scaled matrix entries and the unchanged position.
// The csr_ channel writes the three row scales (Q8.8); it is always ready and
// must only be used while the block is empty.
// From acceptance to rsp_valid an item passes through one register per CORDIC
// cell in the sine-cosine chains, then the matrix product and scaling stages,
// and last the output register. Throughput is one item per cycle while the
// output is not stalled: each CORDIC cell and each matrix stage holds a
// different item. When the receiver stalls, the whole pipeline holds
// and req_ready falls only if the output register is full and not taken.
// Reset clears all valid bits and returns every scale to 1.0.
module euler_world_matrix_builder_unit #(
   parameter int TRIG_ITERATIONS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_pitch_angle,
   input  logic signed [15:0]  req_yaw_angle,
   input  logic signed [15:0]  req_roll_angle,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [24:0]  rsp_m_r1c1,
   output logic signed [24:0]  rsp_m_r1c2,
   output logic signed [24:0]  rsp_m_r1c3,
   output logic signed [24:0]  rsp_m_r2c1,
   output logic signed [24:0]  rsp_m_r2c2,
   output logic signed [24:0]  rsp_m_r2c3,
   output logic signed [24:0]  rsp_m_r3c1,
   output logic signed [24:0]  rsp_m_r3c2,
   output logic signed [24:0]  rsp_m_r3c3,
   output logic signed [31:0]  rsp_trans_x,
   output logic signed [31:0]  rsp_trans_y,
   output logic signed [31:0]  rsp_trans_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);
   // Pipeline depth up to the output register.
   localparam int Depth = TRIG_ITERATIONS + 3;

   logic signed [15:0] scale_ff [3];
   logic [Depth-1:0] vld_ff, vld_in;
   logic out_vld_ff;
   logic adv;
   ewmb_pkg::pos_type pos_ff [TRIG_ITERATIONS][3];
   ewmb_pkg::trig_type trig;
   ewmb_pkg::entry_type ent [9];
   ewmb_pkg::entry_type ent_ff [9];
   ewmb_pkg::pos_type tx, ty, tz, tx_ff, ty_ff, tz_ff;

   // The pipeline advances whenever the output register is free or being taken.
   assign adv = !out_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff[0] <= ewmb_pkg::SCALE_ONE;
         scale_ff[1] <= ewmb_pkg::SCALE_ONE;
         scale_ff[2] <= ewmb_pkg::SCALE_ONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            ewmb_pkg::CSR_SCALE_X: scale_ff[0] <= csr_data;
            ewmb_pkg::CSR_SCALE_Y: scale_ff[1] <= csr_data;
            ewmb_pkg::CSR_SCALE_Z: scale_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   ewmb_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_p (
      .clock(clock), .adv(adv), .angle(req_pitch_angle), .sin_o(trig.sp), .cos_o(trig.cp));
   ewmb_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_y (
      .clock(clock), .adv(adv), .angle(req_yaw_angle), .sin_o(trig.sy), .cos_o(trig.cy));
   ewmb_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_r (
      .clock(clock), .adv(adv), .angle(req_roll_angle), .sin_o(trig.sr), .cos_o(trig.cr));

   // Position rides alongside the CORDIC chain.
   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff[0][0] <= req_pos_x;
         pos_ff[0][1] <= req_pos_y;
         pos_ff[0][2] <= req_pos_z;
         for (int i = 1; i < TRIG_ITERATIONS; i++) pos_ff[i] <= pos_ff[i-1];
      end
   end
   assign trig.px = pos_ff[TRIG_ITERATIONS-1][0];
   assign trig.py = pos_ff[TRIG_ITERATIONS-1][1];
   assign trig.pz = pos_ff[TRIG_ITERATIONS-1][2];

   ewmb_matrix u_mat (
      .clock(clock), .adv(adv), .trig(trig),
      .scale_x(scale_ff[0]), .scale_y(scale_ff[1]), .scale_z(scale_ff[2]),
      .ent(ent), .tx(tx), .ty(ty), .tz(tz)
   );

   assign vld_in = {vld_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_ff <= ent;
         tx_ff <= tx;
         ty_ff <= ty;
         tz_ff <= tz;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_m_r1c1 = ent_ff[0];
   assign rsp_m_r1c2 = ent_ff[1];
   assign rsp_m_r1c3 = ent_ff[2];
   assign rsp_m_r2c1 = ent_ff[3];
   assign rsp_m_r2c2 = ent_ff[4];
   assign rsp_m_r2c3 = ent_ff[5];
   assign rsp_m_r3c1 = ent_ff[6];
   assign rsp_m_r3c2 = ent_ff[7];
   assign rsp_m_r3c3 = ent_ff[8];
   assign rsp_trans_x = tx_ff;
   assign rsp_trans_y = ty_ff;
   assign rsp_trans_z = tz_ff;

   // A stalled response keeps the pipeline frozen.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vld_ff))
      else $error("pipeline moved during stall");
   // An item leaving the last stage shows up at the output next cycle.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[Depth-1] |=> rsp_valid)
      else $error("item lost before output");
   // No response without an item in flight before.
   a_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(vld_ff[Depth-1]))
      else $error("response without item");
endmodule
